// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PRT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define PRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg
// Shared constants and types of the primitive root tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prt_pkg;

  localparam int unsigned BaseW = 30;
  localparam int unsigned CntW  = 4;
  localparam logic [BaseW-1:0] ResetBase = 30'd10;
  localparam logic [2:0] AddrTestBase = 3'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/prt_if.sv =====
// ----------------------------------------------------------------------------
// prt_in_if / prt_out_if
// Valid/ready channels for moduli in and test results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prt_in_if #(
  parameter int unsigned PRIME_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [PRIME_BITS-1:0] prime;

  modport source (output valid, output prime, input ready);
  modport sink   (input valid, input prime, output ready);
endinterface

interface prt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      is_primitive;
  logic [prt_pkg::CntW-1:0]  distinct_factors;

  modport source (output valid, output is_primitive, output distinct_factors, input ready);
  modport sink   (input valid, input is_primitive, input distinct_factors, output ready);
endinterface

// ===== design/prt_ram.sv =====
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/prt_div.sv =====
// ----------------------------------------------------------------------------
// prt_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prt_div #(
  parameter int unsigned DVD_W = 60,
  parameter int unsigned DVS_W = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output prt_pkg::div_stat_t   stat_o,
  output logic [DVD_W-1:0]     quot_o,
  output logic [DVS_W-1:0]     rem_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

// ===== design/primitive_root_test.sv =====
// Work: about sqrt(prime) + k*(2*PRIME_BITS + 1) divider passes, k being the
// number of distinct factors; the passes run one after another on the divider.
// Throughput: one modulus at a time; the next is taken after the result leaves.
// The shared bit-serial divider does all of this work: trial division dominates.
// Reset: asynchronous, active low; test_base returns to 10, sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// primitive_root_test
// Factors prime-1 by trial division, then checks base^((p-1)/q) mod p per factor.
// ----------------------------------------------------------------------------
module primitive_root_test #(
  parameter int unsigned PRIME_BITS  = 30,
  parameter int unsigned MAX_FACTORS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  prt_in_if.sink      in_i,
  prt_out_if.source   out_o
);

  localparam int unsigned PB  = PRIME_BITS;
  localparam int unsigned BW  = prt_pkg::BaseW;
  localparam int unsigned DVW = (2 * PB > BW) ? 2 * PB : BW;
  localparam int unsigned DW  = PB / 2 + 2;
  localparam int unsigned AW  = $clog2(MAX_FACTORS);
  localparam int unsigned SW  = $clog2(MAX_FACTORS + 1);
  localparam int unsigned CW  = prt_pkg::CntW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TRIAL  = 5'd1;
  localparam logic [4:0] S_TREDIV = 5'd2;
  localparam logic [4:0] S_TWAIT  = 5'd3;
  localparam logic [4:0] S_TAIL   = 5'd4;
  localparam logic [4:0] S_BWAIT  = 5'd5;
  localparam logic [4:0] S_FETCH  = 5'd6;
  localparam logic [4:0] S_FREAD  = 5'd7;
  localparam logic [4:0] S_EWAIT  = 5'd8;
  localparam logic [4:0] S_PLOOP  = 5'd9;
  localparam logic [4:0] S_MULR   = 5'd10;
  localparam logic [4:0] S_RST    = 5'd11;
  localparam logic [4:0] S_RWAIT  = 5'd12;
  localparam logic [4:0] S_MULB   = 5'd13;
  localparam logic [4:0] S_SST    = 5'd14;
  localparam logic [4:0] S_SWAIT  = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0]      state_q;
  logic [BW-1:0]   base_q;
  logic [PB-1:0]   p_q, pm1_q, rest_q, bred_q, e_q, r_q, bb_q;
  logic [DW-1:0]   d_q;
  logic [CW-1:0]   count_q;
  logic [SW-1:0]   stored_q, idx_q;
  logic            found_q, ok_q;
  logic [2*PB-1:0] prod_q;

  logic             div_start;
  logic [DVW-1:0]   div_dvd;
  logic [PB-1:0]    div_dvs;
  prt_pkg::div_stat_t div_stat;
  logic [DVW-1:0]   div_quot;
  logic [PB-1:0]    div_rem;

  logic            ram_we;
  logic [PB-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [PB-1:0]   ram_rdata;

  logic [2*DW-1:0] d_sq;
  logic [PB-1:0]   d_ext;
  logic            room;
  logic            cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == prt_pkg::AddrTestBase[2]);
  assign prdata = (paddr[2] == prt_pkg::AddrTestBase[2]) ? {{(32-BW){1'b0}}, base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= prt_pkg::ResetBase;
    end else if (cfg_wr) begin
      base_q <= pwdata[BW-1:0];
    end
  end

  assign d_sq  = (2*DW)'(d_q) * (2*DW)'(d_q);
  assign d_ext = {{(PB-DW){1'b0}}, d_q};
  assign room  = (stored_q < SW'(MAX_FACTORS));

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {{(DVW-PB){1'b0}}, rest_q};
    div_dvs   = d_ext;
    case (state_q)
      S_TRIAL:  div_start = (d_sq <= (2*DW)'(rest_q));
      S_TREDIV: div_start = 1'b1;
      S_TAIL: begin
        div_start = 1'b1;
        div_dvd   = {{(DVW-BW){1'b0}}, base_q};
        div_dvs   = p_q;
      end
      S_FREAD: begin
        div_start = 1'b1;
        div_dvd   = {{(DVW-PB){1'b0}}, pm1_q};
        div_dvs   = ram_rdata;
      end
      S_RST, S_SST: begin
        div_start = 1'b1;
        div_dvd   = DVW'(prod_q);
        div_dvs   = p_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Factor store writes
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rest_q;
    if (state_q == S_TWAIT && div_stat.done && div_rem == '0 && !found_q && room) begin
      ram_we    = 1'b1;
      ram_wdata = d_ext;
    end else if (state_q == S_TAIL && rest_q > PB'(1) && room) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = idx_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      stored_q <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            p_q      <= in_i.prime;
            pm1_q    <= in_i.prime - 1'b1;
            rest_q   <= in_i.prime - 1'b1;
            d_q      <= DW'(2);
            count_q  <= '0;
            stored_q <= '0;
            found_q  <= 1'b0;
            ok_q     <= 1'b0;
            state_q  <= (in_i.prime < PB'(2)) ? S_OUT : S_TRIAL;
          end
        end
        S_TRIAL:  state_q <= div_start ? S_TWAIT : S_TAIL;
        S_TREDIV: state_q <= S_TWAIT;
        S_TWAIT: begin
          if (div_stat.done) begin
            if (div_rem == '0) begin
              // keep dividing out this factor
              rest_q <= div_quot[PB-1:0];
              if (!found_q) begin
                found_q <= 1'b1;
                count_q <= count_q + 1'b1;
                if (room) begin
                  stored_q <= stored_q + 1'b1;
                end
              end
              state_q <= S_TREDIV;
            end else begin
              d_q     <= d_q + 1'b1;
              found_q <= 1'b0;
              state_q <= S_TRIAL;
            end
          end
        end
        S_TAIL: begin
          if (rest_q > PB'(1)) begin
            count_q <= count_q + 1'b1;
            if (room) begin
              stored_q <= stored_q + 1'b1;
            end
          end
          state_q <= S_BWAIT;
        end
        S_BWAIT: begin
          if (div_stat.done) begin
            bred_q  <= div_rem;
            ok_q    <= (div_rem != '0);
            idx_q   <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH:  state_q <= (!ok_q || idx_q == stored_q) ? S_OUT : S_FREAD;
        S_FREAD:  state_q <= S_EWAIT;
        S_EWAIT: begin
          if (div_stat.done) begin
            e_q     <= div_quot[PB-1:0];
            r_q     <= PB'(1);
            bb_q    <= bred_q;
            state_q <= S_PLOOP;
          end
        end
        S_PLOOP: begin
          if (e_q == '0) begin
            if (r_q == PB'(1)) begin
              ok_q <= 1'b0;
            end
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FETCH;
          end else begin
            state_q <= e_q[0] ? S_MULR : S_MULB;
          end
        end
        S_MULR: begin
          prod_q  <= (2*PB)'(r_q) * (2*PB)'(bb_q);
          state_q <= S_RST;
        end
        S_RST:    state_q <= S_RWAIT;
        S_RWAIT: begin
          if (div_stat.done) begin
            r_q     <= div_rem;
            state_q <= S_MULB;
          end
        end
        S_MULB: begin
          prod_q  <= (2*PB)'(bb_q) * (2*PB)'(bb_q);
          state_q <= S_SST;
        end
        S_SST:    state_q <= S_SWAIT;
        S_SWAIT: begin
          if (div_stat.done) begin
            bb_q    <= div_rem;
            e_q     <= e_q >> 1;
            state_q <= S_PLOOP;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = (state_q == S_OUT);
  assign out_o.is_primitive     = ok_q;
  assign out_o.distinct_factors = count_q;

  prt_div #(
    .DVD_W(DVW),
    .DVS_W(PB)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  prt_ram #(
    .WIDTH(PB),
    .DEPTH(MAX_FACTORS)
  ) u_fac_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (stored_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `PRT_ASSERT_NOW(a_ready_excl_valid, clk_i, rst_ni, in_i.ready, !out_o.valid)
  `PRT_ASSERT_NOW(a_start_when_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `PRT_ASSERT_NOW(a_stored_bound, clk_i, rst_ni, ram_we, stored_q < SW'(MAX_FACTORS))
  `PRT_ASSERT_NEXT(a_accept_clears, clk_i, rst_ni, in_i.valid && in_i.ready,
                   stored_q == '0 && count_q == '0)

endmodule
